### sv/icaf_pkg.sv
`timescale 1ns / 1ps
package icaf_pkg;

	localparam int ATAN_TABLE_LEN = 24;

	localparam logic [2:0] REG_BLEND_RATIO = 3'd0;
	localparam logic [2:0] REG_STEP_GAIN   = 3'd1;
	localparam logic [2:0] REG_X_OFFSET    = 3'd2;
	localparam logic [2:0] REG_Y_OFFSET    = 3'd3;
	localparam logic [2:0] REG_Z_OFFSET    = 3'd4;

	localparam logic [15:0] BLEND_RATIO_RESET = 16'd64225;
	localparam logic [31:0] STEP_GAIN_RESET   = 32'd4295;

	typedef struct packed {
		logic busy;
		logic done;
	} icaf_tilt_sts_t;

	function automatic logic [21:0] atan_q16(input logic [4:0] i);
		logic [21:0] v;
		unique case (i)
			5'd0: v = 22'd2949120;
			5'd1: v = 22'd1740967;
			5'd2: v = 22'd919879;
			5'd3: v = 22'd466945;
			5'd4: v = 22'd234379;
			5'd5: v = 22'd117304;
			5'd6: v = 22'd58666;
			5'd7: v = 22'd29335;
			5'd8: v = 22'd14668;
			5'd9: v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

### sv/icaf_tilt.sv
`timescale 1ns / 1ps
module icaf_tilt #(
	parameter int ATAN_ITERATIONS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [15:0]      num,
	input  logic [31:0]             sumsq,
	output icaf_pkg::icaf_tilt_sts_t sts,
	output logic signed [31:0]      angle
);
	import icaf_pkg::*;

	localparam int NITER = (ATAN_ITERATIONS < ATAN_TABLE_LEN) ? ATAN_ITERATIONS : ATAN_TABLE_LEN;

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_SQRT = 3'b010,
		T_CORD = 3'b100
	} tilt_state_t;

	tilt_state_t        state_q;
	logic [4:0]         cnt_q;
	logic [47:0]        n_q;
	logic [25:0]        rem_q;
	logic [23:0]        root_q;
	logic signed [27:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic               zero_q;
	logic               done_q;

	logic [27:0]        rem_try;
	logic [27:0]        trial;
	logic signed [27:0] xs, ys;
	logic signed [31:0] at;

	assign rem_try = {rem_q, n_q[47:46]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign xs      = x_q >>> cnt_q;
	assign ys      = y_q >>> cnt_q;
	assign at      = $signed({10'd0, atan_q16(cnt_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (start) begin
						state_q <= T_SQRT;
						cnt_q   <= '0;
					end
				end
				T_SQRT: begin
					if (cnt_q == 5'd23) begin
						state_q <= T_CORD;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				T_CORD: begin
					if (cnt_q == 5'(NITER - 1)) begin
						state_q <= T_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			T_IDLE: begin
				if (start) begin
					n_q    <= {sumsq, 16'd0};
					rem_q  <= '0;
					root_q <= '0;
					zero_q <= (num == 16'sd0) && (sumsq == 32'd0);
					y_q    <= 28'(num) <<< 8;
					z_q    <= '0;
				end
			end
			T_SQRT: begin
				n_q <= {n_q[45:0], 2'b00};
				if (rem_try >= trial) begin
					rem_q  <= 26'(rem_try - trial);
					root_q <= {root_q[22:0], 1'b1};
					x_q    <= $signed({4'd0, root_q[22:0], 1'b1});
				end else begin
					rem_q  <= rem_try[25:0];
					root_q <= {root_q[22:0], 1'b0};
					x_q    <= $signed({4'd0, root_q[22:0], 1'b0});
				end
			end
			T_CORD: begin
				if (y_q >= 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end
			end
			default: ;
		endcase
	end

	assign sts.busy = (state_q != T_IDLE);
	assign sts.done = done_q;
	assign angle    = zero_q ? 32'sd0 : z_q;
endmodule

### sv/imu_complementary_attitude_filter_top.sv
`timescale 1ns / 1ps
// The shared square root and arctangent unit makes one pass for roll and one for pitch,
// with its iterations clamped to 24.
// A new sample is taken once the previous one has moved into the output register.
// The asynchronous reset clears the angles, loads the register defaults and empties the output.
module imu_complementary_attitude_filter_top #(
	parameter int ATAN_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
	input  logic [95:0] s_tdata,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pitch_deg, roll_deg, yaw_deg
	output logic [95:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);
	import icaf_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SQR   = 7'b0000010,
		ST_ROLL  = 7'b0000100,
		ST_PITCH = 7'b0001000,
		ST_GYRO  = 7'b0010000,
		ST_BLEND = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [2:0]         cnt_q;
	logic [15:0]        ratio_q;
	logic [31:0]        gain_q;
	logic [15:0]        offx_q, offy_q, offz_q;
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic               last_q;
	logic [30:0]        sqx_q, sqy_q, sqz_q;
	logic signed [31:0] acc_roll_q, acc_pitch_q;
	logic signed [32:0] stx_q, sty_q, stz_q;
	logic signed [31:0] s_q;
	logic signed [50:0] sum_q;
	logic signed [31:0] pitch_q, roll_q, yaw_q;
	logic               tilt_start_q;
	logic               m_valid_q;
	logic [95:0]        m_data_q;
	logic               m_last_q;

	logic signed [17:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [50:0] prod;
	logic signed [15:0] tilt_num;
	logic [31:0]        tilt_sumsq;
	icaf_tilt_sts_t     tilt_sts;
	logic signed [31:0] tilt_angle;
	logic signed [16:0] g_diff;
	logic signed [50:0] step_rnd;
	logic signed [33:0] s_sum;
	logic signed [31:0] s_sat;
	logic signed [50:0] blend_rnd;
	logic               in_acc;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: g_diff = 17'(gx_q) - 17'($signed(offx_q));
			2'd1: g_diff = 17'(gy_q) - 17'($signed(offy_q));
			default: g_diff = 17'(gz_q) - 17'($signed(offz_q));
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQR: begin
				unique case (cnt_q[1:0])
					2'd0: begin mul_a = 18'(ax_q); mul_b = 33'(ax_q); end
					2'd1: begin mul_a = 18'(ay_q); mul_b = 33'(ay_q); end
					default: begin mul_a = 18'(az_q); mul_b = 33'(az_q); end
				endcase
			end
			ST_GYRO: begin
				mul_a = 18'(g_diff);
				mul_b = $signed({1'b0, gain_q});
			end
			ST_BLEND: begin
				if (cnt_q[1:0] == 2'd1) begin
					mul_a = $signed({2'b00, ratio_q});
					mul_b = 33'(s_q);
				end else begin
					mul_a = $signed({1'b0, 17'(17'h10000 - {1'b0, ratio_q})});
					mul_b = cnt_q[2] ? 33'(acc_roll_q) : 33'(acc_pitch_q);
				end
			end
			default: ;
		endcase
	end

	assign prod      = mul_a * mul_b;
	assign step_rnd  = prod + 51'sd32768;
	assign blend_rnd = sum_q + 51'sd32768;
	assign s_sum     = cnt_q[2] ? (34'(roll_q) + 34'(sty_q)) : (34'(pitch_q) + 34'(stx_q));

	always_comb begin
		if (s_sum > 34'sd2147483647) begin
			s_sat = 32'sh7FFFFFFF;
		end else if (s_sum < -34'sd2147483648) begin
			s_sat = 32'sh80000000;
		end else begin
			s_sat = s_sum[31:0];
		end
	end

	assign tilt_num   = (state_q == ST_PITCH) ? ax_q : ay_q;
	assign tilt_sumsq = (state_q == ST_PITCH) ? ({1'b0, sqy_q} + {1'b0, sqz_q})
	                                          : ({1'b0, sqx_q} + {1'b0, sqz_q});

	icaf_tilt #(.ATAN_ITERATIONS(ATAN_ITERATIONS)) u_tilt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tilt_start_q),
		.num    (tilt_num),
		.sumsq  (tilt_sumsq),
		.sts    (tilt_sts),
		.angle  (tilt_angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= BLEND_RATIO_RESET;
			gain_q  <= STEP_GAIN_RESET;
			offx_q  <= '0;
			offy_q  <= '0;
			offz_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BLEND_RATIO: ratio_q <= cfg_wdata[15:0];
				REG_STEP_GAIN:   gain_q  <= cfg_wdata;
				REG_X_OFFSET:    offx_q  <= cfg_wdata[15:0];
				REG_Y_OFFSET:    offy_q  <= cfg_wdata[15:0];
				REG_Z_OFFSET:    offz_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			tilt_start_q <= 1'b0;
			m_valid_q    <= 1'b0;
			pitch_q      <= '0;
			roll_q       <= '0;
			yaw_q        <= '0;
		end else begin
			tilt_start_q <= 1'b0;
			if (m_valid_q && m_tready && state_q != ST_DONE) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SQR;
						cnt_q   <= '0;
					end
				end
				ST_SQR: begin
					if (cnt_q == 3'd2) begin
						state_q      <= ST_ROLL;
						tilt_start_q <= 1'b1;
						cnt_q        <= '0;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_ROLL: begin
					if (tilt_sts.done) begin
						state_q      <= ST_PITCH;
						tilt_start_q <= 1'b1;
					end
				end
				ST_PITCH: begin
					if (tilt_sts.done) begin
						state_q <= ST_GYRO;
						cnt_q   <= '0;
					end
				end
				ST_GYRO: begin
					if (cnt_q == 3'd2) begin
						state_q <= ST_BLEND;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_BLEND: begin
					if (cnt_q == 3'd0) begin
						yaw_q <= yaw_q - stz_q[31:0];
					end
					if (cnt_q == 3'd3) begin
						pitch_q <= blend_rnd[47:16];
					end
					if (cnt_q == 3'd7) begin
						roll_q  <= blend_rnd[47:16];
						state_q <= ST_DONE;
					end
					cnt_q <= cnt_q + 3'd1;
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ax_q   <= s_tdata[15:0];
			ay_q   <= s_tdata[31:16];
			az_q   <= s_tdata[47:32];
			gx_q   <= s_tdata[63:48];
			gy_q   <= s_tdata[79:64];
			gz_q   <= s_tdata[95:80];
			last_q <= s_tlast;
		end
		if (state_q == ST_SQR) begin
			unique case (cnt_q[1:0])
				2'd0: sqx_q <= prod[30:0];
				2'd1: sqy_q <= prod[30:0];
				default: sqz_q <= prod[30:0];
			endcase
		end
		if (state_q == ST_ROLL && tilt_sts.done) begin
			acc_roll_q <= tilt_angle;
		end
		if (state_q == ST_PITCH && tilt_sts.done) begin
			acc_pitch_q <= tilt_angle;
		end
		if (state_q == ST_GYRO) begin
			unique case (cnt_q[1:0])
				2'd0: stx_q <= step_rnd[48:16];
				2'd1: sty_q <= step_rnd[48:16];
				default: stz_q <= step_rnd[48:16];
			endcase
		end
		if (state_q == ST_BLEND) begin
			unique case (cnt_q[1:0])
				2'd0: s_q <= s_sat;
				2'd1: sum_q <= prod;
				2'd2: sum_q <= sum_q + prod;
				default: ;
			endcase
		end
		if (state_q == ST_DONE && (!m_valid_q || m_tready)) begin
			m_data_q <= {yaw_q, roll_q, pitch_q};
			m_last_q <= last_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
endmodule

### sv/icaf_checker.sv
`timescale 1ns / 1ps
module icaf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while a sample is in progress");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too soon after a request");

	a_busy2: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 !s_tready)
		else $error("sample processing ended too early");
endmodule

bind imu_complementary_attitude_filter_top icaf_checker u_icaf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
